// File: design/assert_macros.svh
// Shared assertion macros; clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/spc_pkg.sv
`timescale 1ns / 1ps
package spc_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int NORMAL_WIDTH = 16;
    localparam int NORMAL_FRAC  = NORMAL_WIDTH - 2;
    localparam int TOL_WIDTH    = 16;
    localparam int LAMBDA_FRAC  = 63 - COORD_WIDTH;
    localparam int LAM_W        = LAMBDA_FRAC + 1;
    localparam int PROD_W       = COORD_WIDTH + NORMAL_WIDTH;
    localparam int DIST_W       = PROD_W + 3;
    localparam int DEN_W        = DIST_W + 1;
    localparam int DIR_W        = COORD_WIDTH + 1;
    localparam int PROD2_W      = LAM_W + DIR_W;
    localparam int OFF_W        = PROD2_W - LAMBDA_FRAC;
    localparam int SUM_W        = OFF_W + 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = COORD_WIDTH;
    // dist stages + one per quotient bit + interpolation stages
    localparam int LATENCY      = 3 + LAM_W + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_TOL      = 3'd4
    } spc_cfg_idx_t;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic signed [COORD_WIDTH-1:0]  plane_offset;
        logic [TOL_WIDTH-1:0]           parallel_tolerance;
    } spc_cfg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_z;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] end_z;
    } spc_in_t;

    typedef struct packed {
        logic                          seg_valid;
        logic                          was_clipped;
        logic signed [COORD_WIDTH-1:0] out_start_x;
        logic signed [COORD_WIDTH-1:0] out_start_y;
        logic signed [COORD_WIDTH-1:0] out_start_z;
        logic signed [COORD_WIDTH-1:0] out_end_x;
        logic signed [COORD_WIDTH-1:0] out_end_y;
        logic signed [COORD_WIDTH-1:0] out_end_z;
    } spc_out_t;

    // Segment plus side flags carried down the pipeline.
    typedef struct packed {
        spc_in_t seg;
        logic    a_front;
        logic    b_front;
        logic    clip;
    } spc_item_t;

    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [NORMAL_WIDTH-1:0] n,
        input logic signed [COORD_WIDTH-1:0]  c
    );
        logic signed [PROD_W-1:0] ne;
        logic signed [PROD_W-1:0] ce;
        ne = PROD_W'(n);
        ce = PROD_W'(c);
        return ne * ce;
    endfunction

endpackage

// File: design/spc_dist.sv
`timescale 1ns / 1ps
module spc_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  spc_pkg::spc_in_t               seg,
    input  spc_pkg::spc_cfg_t              cfg,
    output logic                           out_valid,
    output spc_pkg::spc_item_t             item,
    output logic [spc_pkg::DEN_W-1:0]      num,
    output logic [spc_pkg::DEN_W-1:0]      den
);
    import spc_pkg::*;

    logic signed [COORD_WIDTH-1:0]  a_c [3];
    logic signed [COORD_WIDTH-1:0]  b_c [3];
    logic signed [NORMAL_WIDTH-1:0] n_c [3];

    logic                     v1_reg, v2_reg, v3_reg;
    spc_in_t                  seg1_reg, seg2_reg;
    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    logic signed [DIST_W-1:0] doff_reg;
    logic signed [DIST_W-1:0] da_reg, db_reg;
    spc_item_t                item3_reg;
    logic [DEN_W-1:0]         num3_reg, den3_reg;

    logic signed [DEN_W-1:0] prj, dae;
    logic [DEN_W-1:0]        den_next, num_next, tol_sh;
    logic                    a_front, b_front, parallel;

    assign a_c[0] = seg.start_x;
    assign a_c[1] = seg.start_y;
    assign a_c[2] = seg.start_z;
    assign b_c[0] = seg.end_x;
    assign b_c[1] = seg.end_y;
    assign b_c[2] = seg.end_z;
    assign n_c[0] = cfg.normal_x;
    assign n_c[1] = cfg.normal_y;
    assign n_c[2] = cfg.normal_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: products and scaled offset
    always_ff @(posedge clk)
    begin
        seg1_reg <= seg;
        doff_reg <= DIST_W'(cfg.plane_offset) <<< NORMAL_FRAC;
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i] <= smul(n_c[i], a_c[i]);
            pb_reg[i] <= smul(n_c[i], b_c[i]);
        end
    end

    // stage 2: distances
    always_ff @(posedge clk)
    begin
        seg2_reg <= seg1_reg;
        da_reg   <= DIST_W'(pa_reg[0]) + DIST_W'(pa_reg[1]) + DIST_W'(pa_reg[2]) + doff_reg;
        db_reg   <= DIST_W'(pb_reg[0]) + DIST_W'(pb_reg[1]) + DIST_W'(pb_reg[2]) + doff_reg;
    end

    // stage 3: sides, divider operands, parallel test
    always_comb
    begin
        a_front  = !da_reg[DIST_W-1];
        b_front  = !db_reg[DIST_W-1];
        prj      = DEN_W'(db_reg) - DEN_W'(da_reg);
        den_next = prj[DEN_W-1] ? DEN_W'(-prj) : DEN_W'(prj);
        dae      = DEN_W'(da_reg);
        num_next = dae[DEN_W-1] ? DEN_W'(-dae) : DEN_W'(dae);
        tol_sh   = DEN_W'(cfg.parallel_tolerance) << NORMAL_FRAC;
        parallel = den_next <= tol_sh;
    end

    always_ff @(posedge clk)
    begin
        item3_reg.seg     <= seg2_reg;
        item3_reg.a_front <= a_front;
        item3_reg.b_front <= b_front;
        item3_reg.clip    <= (a_front ^ b_front) && !parallel;
        num3_reg          <= num_next;
        den3_reg          <= den_next;
    end

    assign out_valid = v3_reg;
    assign item      = item3_reg;
    assign num       = num3_reg;
    assign den       = den3_reg;

endmodule

// File: design/spc_div.sv
`timescale 1ns / 1ps
module spc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  spc_pkg::spc_item_t          in_item,
    input  logic [spc_pkg::DEN_W-1:0]   num,
    input  logic [spc_pkg::DEN_W-1:0]   den,
    output logic                        out_valid,
    output spc_pkg::spc_item_t          out_item,
    output logic [spc_pkg::LAM_W-1:0]   lam
);
    import spc_pkg::*;

    // One quotient bit per stage; the first stage makes the integer bit.
    logic             v_reg    [LAM_W];
    spc_item_t        item_reg [LAM_W];
    logic [DEN_W-1:0] r_reg    [LAM_W];
    logic [DEN_W-1:0] den_reg  [LAM_W];
    logic [LAM_W-1:0] q_reg    [LAM_W];

    for (genvar i = 0; i < LAM_W; i++)
    begin : g_step
        logic             v_in;
        spc_item_t        item_in;
        logic [DEN_W-1:0] r_in, den_in;
        logic [LAM_W-1:0] q_in;
        logic [DEN_W:0]   t, diff;
        logic             ge;
        logic [DEN_W-1:0] r_next;
        logic [LAM_W-1:0] q_next;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_item;
            assign r_in    = num;
            assign den_in  = den;
            assign q_in    = '0;
            assign t       = {1'b0, r_in};
        end
        else
        begin : g_rest
            assign v_in    = v_reg[i-1];
            assign item_in = item_reg[i-1];
            assign r_in    = r_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign t       = {r_in, 1'b0};
        end

        assign diff   = t - {1'b0, den_in};
        assign ge     = t >= {1'b0, den_in};
        assign r_next = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        assign q_next = {q_in[LAM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            item_reg[i] <= item_in;
            r_reg[i]    <= r_next;
            den_reg[i]  <= den_in;
            q_reg[i]    <= q_next;
        end
    end

    assign out_valid = v_reg[LAM_W-1];
    assign out_item  = item_reg[LAM_W-1];
    assign lam       = q_reg[LAM_W-1];

endmodule

// File: design/spc_interp.sv
`timescale 1ns / 1ps
module spc_interp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  spc_pkg::spc_item_t          item,
    input  logic [spc_pkg::LAM_W-1:0]   lam,
    output logic                        done,
    output spc_pkg::spc_out_t           result
);
    import spc_pkg::*;

    localparam logic signed [SUM_W-1:0] COORD_HI = SUM_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] COORD_LO = -COORD_HI - SUM_W'(1);

    logic signed [COORD_WIDTH-1:0] a_c [3];
    logic signed [COORD_WIDTH-1:0] b_c [3];
    logic signed [DIR_W-1:0]       dir [3];

    logic             va_reg, vb_reg, done_reg;
    spc_item_t        itema_reg, itemb_reg;
    logic [LAM_W-1:0] lam_reg;
    logic [DIR_W-1:0] dmag_reg [3];
    logic             dneg_reg [3];
    logic             dnegb_reg [3];
    logic [PROD2_W-1:0] prod_reg [3];
    spc_out_t         result_reg;

    logic [PROD2_W-1:0]            rnd [3];
    logic signed [SUM_W-1:0]       offs [3];
    logic signed [SUM_W-1:0]       sum [3];
    logic signed [COORD_WIDTH-1:0] hit [3];
    logic signed [COORD_WIDTH-1:0] sa [3];
    logic signed [COORD_WIDTH-1:0] sb [3];
    spc_out_t                      result_next;

    assign a_c[0] = item.seg.start_x;
    assign a_c[1] = item.seg.start_y;
    assign a_c[2] = item.seg.start_z;
    assign b_c[0] = item.seg.end_x;
    assign b_c[1] = item.seg.end_y;
    assign b_c[2] = item.seg.end_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            vb_reg   <= va_reg;
            done_reg <= vb_reg;
        end
    end

    // stage A: direction magnitude and sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dir[i] = DIR_W'(b_c[i]) - DIR_W'(a_c[i]);
    end

    always_ff @(posedge clk)
    begin
        itema_reg <= item;
        lam_reg   <= lam;
        for (int i = 0; i < 3; i++)
        begin
            dmag_reg[i] <= dir[i][DIR_W-1] ? DIR_W'(-dir[i]) : DIR_W'(dir[i]);
            dneg_reg[i] <= dir[i][DIR_W-1];
        end
    end

    // stage B: lambda times |dir|
    always_ff @(posedge clk)
    begin
        itemb_reg <= itema_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i]  <= PROD2_W'(lam_reg) * PROD2_W'(dmag_reg[i]);
            dnegb_reg[i] <= dneg_reg[i];
        end
    end

    // stage C: round, step from start, saturate, select
    always_comb
    begin
        sa[0] = itemb_reg.seg.start_x;
        sa[1] = itemb_reg.seg.start_y;
        sa[2] = itemb_reg.seg.start_z;
        sb[0] = itemb_reg.seg.end_x;
        sb[1] = itemb_reg.seg.end_y;
        sb[2] = itemb_reg.seg.end_z;
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]  = prod_reg[i] + (PROD2_W'(1) << (LAMBDA_FRAC - 1));
            offs[i] = SUM_W'(rnd[i][PROD2_W-1:LAMBDA_FRAC]);
            sum[i]  = dnegb_reg[i] ? SUM_W'(sa[i]) - offs[i] : SUM_W'(sa[i]) + offs[i];
            if (sum[i] > COORD_HI)
                hit[i] = COORD_HI[COORD_WIDTH-1:0];
            else if (sum[i] < COORD_LO)
                hit[i] = COORD_LO[COORD_WIDTH-1:0];
            else
                hit[i] = sum[i][COORD_WIDTH-1:0];
            if (itemb_reg.clip)
            begin
                if (itemb_reg.a_front)
                    sb[i] = hit[i];
                else
                    sa[i] = hit[i];
            end
        end

        result_next.seg_valid   = itemb_reg.a_front || itemb_reg.b_front;
        result_next.was_clipped = itemb_reg.clip;
        result_next.out_start_x = sa[0];
        result_next.out_start_y = sa[1];
        result_next.out_start_z = sa[2];
        result_next.out_end_x   = sb[0];
        result_next.out_end_y   = sb[1];
        result_next.out_end_z   = sb[2];
        // drop coordinates of a segment fully behind the plane
        if (!result_next.seg_valid)
            result_next = '0;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: design/segment_plane_clipper_core.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   start / busy         segment (spc_in_t)
// result    done (strobe)        result (spc_out_t)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is taken every cycle; busy stays low.
// Each result shows on done after its request passes 3 distance stages,
// 32 restoring divider stages for lambda and 3 interpolation stages.
// Reset clears the stage valid bits and loads the plane registers with their
// defaults. The receiver cannot stall; cfg_ready stays high, so every config write is taken.
module segment_plane_clipper_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  spc_pkg::spc_in_t                  segment,
    output logic                              done,
    output spc_pkg::spc_out_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spc_pkg::*;

    `include "assert_macros.svh"

    spc_cfg_t         cfg_reg;
    logic             accept;
    logic             dist_valid, div_valid;
    spc_item_t        dist_item, div_item;
    logic [DEN_W-1:0] num, den;
    logic [LAM_W-1:0] lam;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_x           <= '0;
            cfg_reg.normal_y           <= '0;
            cfg_reg.normal_z           <= NORMAL_WIDTH'(16384);
            cfg_reg.plane_offset       <= '0;
            cfg_reg.parallel_tolerance <= TOL_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (spc_cfg_idx_t'(cfg_index))
                CFG_NORMAL_X: cfg_reg.normal_x           <= cfg_data[NORMAL_WIDTH-1:0];
                CFG_NORMAL_Y: cfg_reg.normal_y           <= cfg_data[NORMAL_WIDTH-1:0];
                CFG_NORMAL_Z: cfg_reg.normal_z           <= cfg_data[NORMAL_WIDTH-1:0];
                CFG_OFFSET:   cfg_reg.plane_offset       <= cfg_data[COORD_WIDTH-1:0];
                CFG_TOL:      cfg_reg.parallel_tolerance <= cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    spc_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .seg       (segment),
        .cfg       (cfg_reg),
        .out_valid (dist_valid),
        .item      (dist_item),
        .num       (num),
        .den       (den)
    );

    spc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_valid),
        .in_item   (dist_item),
        .num       (num),
        .den       (den),
        .out_valid (div_valid),
        .out_item  (div_item),
        .lam       (lam)
    );

    spc_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .item     (div_item),
        .lam      (lam),
        .done     (done),
        .result   (result)
    );

    `ASSERT_IMPL(a_latency, accept, ##38 done, "request did not complete in 38 cycles")
    `ASSERT_IMPL(a_no_orphan, done, $past(accept, 38), "result without a request")
    `ASSERT_IMPL(a_clip_valid, done && result.was_clipped, result.seg_valid,
                 "clipped result marked empty")
    `ASSERT_IMPL(a_empty_zero, done && !result.seg_valid,
                 result.out_start_x == 0 && result.out_end_x == 0,
                 "empty result carries coordinates")

endmodule

// File: tb/tb_segment_plane_clipper_core.sv
`timescale 1ns / 1ps
module tb_segment_plane_clipper_core;
    import spc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_5 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = CFG_IDX_W'(7);
    localparam int DRAIN_CYCLES = LATENCY + 8;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    spc_in_t               segment;
    logic                  done;
    spc_out_t              result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // plane as the block should hold it
    logic signed [NORMAL_WIDTH-1:0] plane_nx;
    logic signed [NORMAL_WIDTH-1:0] plane_ny;
    logic signed [NORMAL_WIDTH-1:0] plane_nz;
    logic signed [COORD_WIDTH-1:0]  plane_d;
    logic [TOL_WIDTH-1:0]           plane_tol;

    spc_out_t clipped_q[$];
    int       error_count;
    int       burst_left;

    segment_plane_clipper_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .segment   (segment),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic spc_out_t clip_segment(input spc_in_t s);
        spc_out_t        o;
        longint          a[3];
        longint          b[3];
        longint          da;
        longint          db;
        longint          prj;
        longint          dir;
        longint          v;
        longint unsigned den;
        longint unsigned num;
        longint unsigned lam;
        longint unsigned rem;
        longint unsigned mdir;
        longint unsigned off;
        logic            a_front;
        logic            b_front;
        a[0] = s.start_x; a[1] = s.start_y; a[2] = s.start_z;
        b[0] = s.end_x;   b[1] = s.end_y;   b[2] = s.end_z;
        da = longint'(plane_nx) * a[0] + longint'(plane_ny) * a[1]
           + longint'(plane_nz) * a[2] + (longint'(plane_d) <<< NORMAL_FRAC);
        db = longint'(plane_nx) * b[0] + longint'(plane_ny) * b[1]
           + longint'(plane_nz) * b[2] + (longint'(plane_d) <<< NORMAL_FRAC);
        a_front = (da >= 0);
        b_front = (db >= 0);
        o = '0;
        if (!a_front && !b_front)
            return o;
        o.seg_valid   = 1'b1;
        o.out_start_x = s.start_x; o.out_start_y = s.start_y; o.out_start_z = s.start_z;
        o.out_end_x   = s.end_x;   o.out_end_y   = s.end_y;   o.out_end_z   = s.end_z;
        if (a_front && b_front)
            return o;
        prj = db - da;
        den = (prj < 0) ? -prj : prj;
        if (den <= (longint'(plane_tol) << NORMAL_FRAC))
            return o;
        num = (da < 0) ? -da : da;
        if (num >= den)
            lam = longint'(1) << LAMBDA_FRAC;
        else
        begin
            lam = 0;
            rem = num;
            for (int i = 0; i < LAMBDA_FRAC; i++)
            begin
                rem = rem << 1;
                lam = lam << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    lam = lam | 1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            dir  = b[i] - a[i];
            mdir = (dir < 0) ? -dir : dir;
            off  = (lam * mdir + (longint'(1) << (LAMBDA_FRAC - 1))) >> LAMBDA_FRAC;
            v    = (dir < 0) ? a[i] - longint'(off) : a[i] + longint'(off);
            if (a_front)
            begin
                case (i)
                    0: o.out_end_x = sat_coord(v);
                    1: o.out_end_y = sat_coord(v);
                    default: o.out_end_z = sat_coord(v);
                endcase
            end
            else
            begin
                case (i)
                    0: o.out_start_x = sat_coord(v);
                    1: o.out_start_y = sat_coord(v);
                    default: o.out_start_z = sat_coord(v);
                endcase
            end
        end
        o.was_clipped = 1'b1;
        return o;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // results are stable around the falling edge and checked there
    always @(negedge clk)
    begin
        spc_out_t exp_r;
        if (rst_n && done)
        begin
            if (clipped_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                exp_r = clipped_q.pop_front();
                check_field("seg_valid", exp_r.seg_valid, result.seg_valid);
                check_field("was_clipped", exp_r.was_clipped, result.was_clipped);
                check_field("out_start_x", exp_r.out_start_x, result.out_start_x);
                check_field("out_start_y", exp_r.out_start_y, result.out_start_y);
                check_field("out_start_z", exp_r.out_start_z, result.out_start_z);
                check_field("out_end_x", exp_r.out_end_x, result.out_end_x);
                check_field("out_end_y", exp_r.out_end_y, result.out_end_y);
                check_field("out_end_z", exp_r.out_end_z, result.out_end_z);
            end
        end
    end

    task automatic send_segment(input spc_in_t s);
        logic taken;
        start   <= 1'b1;
        segment <= s;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        clipped_q = {clipped_q, clip_segment(s)};
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (clipped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NORMAL_X: plane_nx  = val[NORMAL_WIDTH-1:0];
            CFG_NORMAL_Y: plane_ny  = val[NORMAL_WIDTH-1:0];
            CFG_NORMAL_Z: plane_nz  = val[NORMAL_WIDTH-1:0];
            CFG_OFFSET:   plane_d   = val;
            CFG_TOL:      plane_tol = val[TOL_WIDTH-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_plane(input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz,
                             input logic [31:0] d, input logic [31:0] tol);
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_OFFSET, d);
        write_reg(CFG_TOL, tol);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return 32'($signed($urandom_range(0, 4000)) - 2000);
            default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff - $urandom_range(0, 9)
                                                        : 32'h8000_0000 + $urandom_range(0, 9);
        endcase
    endfunction

    function automatic spc_in_t rand_segment();
        spc_in_t s;
        s.start_x = rand_coord(); s.start_y = rand_coord(); s.start_z = rand_coord();
        s.end_x   = rand_coord(); s.end_y   = rand_coord(); s.end_z   = rand_coord();
        return s;
    endfunction

    function automatic spc_in_t make_seg(input int ax, input int ay, input int az,
                                         input int bx, input int by, input int bz);
        spc_in_t s;
        s.start_x = ax; s.start_y = ay; s.start_z = az;
        s.end_x   = bx; s.end_y   = by; s.end_z   = bz;
        return s;
    endfunction

    task automatic test_directed();
        int one;
        one = 1 << 16;
        // default plane is z = 0
        send_segment(make_seg(0, 0, one, one, one, 2 * one));          // both in front
        send_segment(make_seg(0, 0, -one, one, one, -2 * one));        // both behind
        send_segment(make_seg(0, 0, -one, 2 * one, 4 * one, one));     // start behind
        send_segment(make_seg(one, -one, 3 * one, -one, one, -one));   // end behind
        send_segment(make_seg(5, 7, 0, 9, 3, -1));                     // start on plane
        send_segment(make_seg(5, 7, -1, 9, 3, 0));                     // end on plane, within parallel tolerance
        send_segment(make_seg(0, 0, -1, 0, 0, 0));                     // parallel within tolerance
        send_segment(make_seg(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 32'h80000000));
        send_segment(make_seg(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_segment(make_seg(32'hffffffff, 0, 32'hffffffff, 0, 32'hffffffff, 0));
        wait_idle();
        // zero normal: offset alone decides the side
        set_plane(0, 0, 0, 32'hffff_0000, 0);
        send_segment(make_seg(0, 0, -one, one, one, one));
        wait_idle();
        write_reg(CFG_OFFSET, 0);
        send_segment(make_seg(0, 0, -one, one, one, one));
        wait_idle();
        // extreme normal and offset, unused indexes must be ignored
        set_plane(32'h8000, 32'h7fff, 32'h8000, 32'h7fff_ffff, 16'hffff);
        write_reg(CFG_UNUSED_5, 32'hffff_ffff);
        write_reg(CFG_UNUSED_7, 32'h0000_1234);
        send_segment(make_seg(0, 0, 0, 32'h7fffffff, 0, 32'h7fffffff));
        send_segment(make_seg(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 32'h80000000));
        send_segment(make_seg(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        wait_idle();
    endtask

    task automatic test_random_plane(input int count, input logic [31:0] nx,
                                     input logic [31:0] ny, input logic [31:0] nz,
                                     input logic [31:0] d, input logic [31:0] tol);
        set_plane(nx, ny, nz, d, tol);
        repeat (count) send_segment(rand_segment());
        wait_idle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        segment     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_NORMAL_X;
        cfg_data    = '0;
        error_count = 0;
        burst_left  = 0;
        plane_nx    = 0;
        plane_ny    = 0;
        plane_nz    = 16384;
        plane_d     = 0;
        plane_tol   = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_plane(150, 0, 0, 16384, 0, 1);
        test_random_plane(150, 32'h8000, 32'h8000, 32'h8000, 32'h8000_0000, 0);
        test_random_plane(150, 32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff_ffff, 16'hffff);
        test_random_plane(150, 16384, 0, 0, 0, 0);
        repeat (3)
            test_random_plane(150, $urandom(), $urandom(), $urandom(),
                              ($urandom_range(0, 1) != 0) ? $urandom()
                                  : 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)),
                              $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 64));
        test_random_plane(50, 0, 0, 0, $urandom(), $urandom());

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
